### src/fwps_pkg.sv
`timescale 1ns / 1ps

package fwps_pkg;

  localparam int DefQueueDepth  = 16;
  localparam int DefPayloadBits = 64;
  localparam int FieldPayloadW  = 64;
  localparam int FieldPrioW     = 8;
  localparam int OccupancyW     = 5;
  localparam int ApbAddrW       = 3;
  localparam int ApbDataW       = 32;

  localparam logic REG_LOWEST  = 1'b0;
  localparam logic REG_HIGHEST = 1'b1;

  localparam logic [FieldPrioW-1:0] LowestReset  = 8'd0;
  localparam logic [FieldPrioW-1:0] HighestReset = 8'd255;

  typedef enum logic [1:0] {
    KIND_APPEND      = 2'd0,
    KIND_REMOVE_HEAD = 2'd1,
    KIND_REMOVE_EQ   = 2'd2,
    KIND_REMOVE_GE   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_BADPRIO = 2'd1,
    STATUS_FULL    = 2'd2,
    STATUS_NONE    = 2'd3
  } status_e;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_e;

  typedef struct packed {
    kind_e                   kind;
    logic [FieldPayloadW-1:0] payload;
    logic [FieldPrioW-1:0]    priority_req;
  } in_item_t;

  typedef struct packed {
    status_e                  status;
    logic [FieldPayloadW-1:0] out_payload;
    logic [FieldPrioW-1:0]    out_priority;
    logic [OccupancyW-1:0]    occupancy;
  } out_item_t;

  typedef struct packed {
    logic [FieldPrioW-1:0] lowest;
    logic [FieldPrioW-1:0] highest;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic step;
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    logic done;
  } dp_status_t;

endpackage

### src/fwps_ctrl.sv
`timescale 1ns / 1ps

module fwps_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  input  fwps_pkg::dp_status_t   dp_status_i,
  output fwps_pkg::dp_cmd_t      dp_cmd_o
);

  fwps_pkg::state_e state_q, state_d;
  logic             out_valid_q, out_valid_d;
  logic             slot_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fwps_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign slot_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d         = state_q;
    dp_cmd_o.load   = 1'b0;
    dp_cmd_o.step   = 1'b0;
    dp_cmd_o.commit = 1'b0;
    in_stall_o      = 1'b1;
    out_valid_d     = out_valid_q && out_stall_i;
    unique case (state_q)
      fwps_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          dp_cmd_o.load = 1'b1;
          state_d       = fwps_pkg::ST_SCAN;
        end
      end
      fwps_pkg::ST_SCAN: begin
        if (!dp_status_i.done) begin
          dp_cmd_o.step = 1'b1;
        end else if (slot_free) begin
          dp_cmd_o.commit = 1'b1;
          out_valid_d     = 1'b1;
          state_d         = fwps_pkg::ST_IDLE;
        end
      end
      default: state_d = fwps_pkg::ST_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

### src/fwps_dpath.sv
`timescale 1ns / 1ps

module fwps_dpath #(
  parameter int QUEUE_DEPTH  = fwps_pkg::DefQueueDepth,
  parameter int PAYLOAD_BITS = fwps_pkg::DefPayloadBits,
  localparam int CntW = $clog2(QUEUE_DEPTH + 1),
  localparam int IdxW = $clog2(QUEUE_DEPTH)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  fwps_pkg::cfg_t         cfg_i,
  input  fwps_pkg::in_item_t     in_data_i,
  input  fwps_pkg::dp_cmd_t      dp_cmd_i,
  output fwps_pkg::dp_status_t   dp_status_o,
  output logic [CntW-1:0]        count_o,
  output fwps_pkg::out_item_t    out_data_o
);

  fwps_pkg::in_item_t          req_q;
  logic                        prio_ok_q;
  logic [CntW-1:0]             scan_q;
  logic [CntW-1:0]             count_q, count_d;
  logic [PAYLOAD_BITS-1:0]     pay_q [QUEUE_DEPTH];
  logic [fwps_pkg::FieldPrioW-1:0] pri_q [QUEUE_DEPTH];
  fwps_pkg::out_item_t         res_q, res_d;

  logic [IdxW-1:0]             idx;
  logic [PAYLOAD_BITS-1:0]     sel_pay;
  logic [fwps_pkg::FieldPrioW-1:0] sel_pri;
  logic                        in_range, hit, bad, is_append, full;
  logic                        append_ok, remove_ok;

  assign idx     = scan_q[IdxW-1:0];
  assign sel_pay = pay_q[idx];
  assign sel_pri = pri_q[idx];

  assign is_append = (req_q.kind == fwps_pkg::KIND_APPEND);
  assign bad       = !prio_ok_q && (req_q.kind != fwps_pkg::KIND_REMOVE_HEAD);
  assign full      = (count_q >= CntW'(QUEUE_DEPTH));
  assign in_range  = (scan_q < count_q);

  always_comb begin
    case (req_q.kind)
      fwps_pkg::KIND_REMOVE_HEAD: hit = in_range;
      fwps_pkg::KIND_REMOVE_EQ:   hit = in_range && (sel_pri == req_q.priority_req);
      fwps_pkg::KIND_REMOVE_GE:   hit = in_range && (sel_pri >= req_q.priority_req);
      default:                    hit = 1'b0;
    endcase
  end

  assign dp_status_o.done = is_append || bad || hit || !in_range;

  assign append_ok = is_append && !bad && !full;
  assign remove_ok = !is_append && !bad && hit;

  always_comb begin
    count_d = count_q;
    if (append_ok) begin
      count_d = count_q + CntW'(1);
    end else if (remove_ok) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_comb begin
    res_d.out_payload  = '0;
    res_d.out_priority = '0;
    res_d.occupancy    = fwps_pkg::OccupancyW'(count_d);
    if (bad) begin
      res_d.status = fwps_pkg::STATUS_BADPRIO;
    end else if (is_append) begin
      res_d.status = full ? fwps_pkg::STATUS_FULL : fwps_pkg::STATUS_OK;
    end else if (hit) begin
      res_d.status       = fwps_pkg::STATUS_OK;
      res_d.out_payload  = fwps_pkg::FieldPayloadW'(sel_pay);
      res_d.out_priority = sel_pri;
    end else begin
      res_d.status = fwps_pkg::STATUS_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      scan_q  <= '0;
    end else begin
      if (dp_cmd_i.load) begin
        scan_q <= '0;
      end else if (dp_cmd_i.step) begin
        scan_q <= scan_q + CntW'(1);
      end
      if (dp_cmd_i.commit) begin
        count_q <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (dp_cmd_i.load) begin
      req_q     <= in_data_i;
      prio_ok_q <= (in_data_i.priority_req >= cfg_i.lowest) &&
                   (in_data_i.priority_req <= cfg_i.highest);
    end
    if (dp_cmd_i.commit) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (dp_cmd_i.commit && remove_ok && (CntW'(i) >= scan_q) && (i + 1 < QUEUE_DEPTH)) begin
        pay_q[i] <= pay_q[(i + 1) % QUEUE_DEPTH];
        pri_q[i] <= pri_q[(i + 1) % QUEUE_DEPTH];
      end else if (dp_cmd_i.commit && append_ok && (CntW'(i) == count_q)) begin
        pay_q[i] <= req_q.payload[PAYLOAD_BITS-1:0];
        pri_q[i] <= req_q.priority_req;
      end
    end
  end

  assign count_o    = count_q;
  assign out_data_o = res_q;

endmodule

### src/fifo_with_priority_select_dequeue.sv
`timescale 1ns / 1ps
// Channel | Handshake                          | Payload
// in      | in_valid_i / in_stall_o            | in_data_i  (kind, payload, priority_req)
// out     | out_valid_o / out_stall_i          | out_data_o (status, out_payload,
//         |                                    |             out_priority, occupancy)
// config  | psel, penable, pwrite, pready      | paddr, pwdata, prdata
//
// One item at a time: after acceptance a match removal with a valid priority scans the
// queue one entry per cycle in the priority compare, stopping at the hit (or at the
// occupancy when nothing matches); other items need no scan. With the output free the
// result is then registered, and the next item is taken after that.
// Reset empties the queue and loads the priority bounds with 0 and 255.
// A result held by out_stall_i delays the next item's result, not its acceptance.

module fifo_with_priority_select_dequeue #(
  parameter int QUEUE_DEPTH  = fwps_pkg::DefQueueDepth,
  parameter int PAYLOAD_BITS = fwps_pkg::DefPayloadBits
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  fwps_pkg::in_item_t                 in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output fwps_pkg::out_item_t                out_data_o,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [fwps_pkg::ApbAddrW-1:0]      paddr,
  input  logic [fwps_pkg::ApbDataW-1:0]      pwdata,
  output logic [fwps_pkg::ApbDataW-1:0]      prdata,
  output logic                               pready
);

  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  fwps_pkg::cfg_t       cfg_q;
  fwps_pkg::dp_cmd_t    dp_cmd;
  fwps_pkg::dp_status_t dp_status;
  logic [CntW-1:0]      count;
  logic                 wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.lowest  <= fwps_pkg::LowestReset;
      cfg_q.highest <= fwps_pkg::HighestReset;
    end else if (wr_en) begin
      unique case (paddr[2])
        fwps_pkg::REG_LOWEST:  cfg_q.lowest  <= pwdata[fwps_pkg::FieldPrioW-1:0];
        fwps_pkg::REG_HIGHEST: cfg_q.highest <= pwdata[fwps_pkg::FieldPrioW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      fwps_pkg::REG_LOWEST:  prdata = fwps_pkg::ApbDataW'(cfg_q.lowest);
      fwps_pkg::REG_HIGHEST: prdata = fwps_pkg::ApbDataW'(cfg_q.highest);
      default:               prdata = '0;
    endcase
  end

  fwps_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .dp_status_i (dp_status),
    .dp_cmd_o    (dp_cmd)
  );

  fwps_dpath #(
    .QUEUE_DEPTH  (QUEUE_DEPTH),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_data_i   (in_data_i),
    .dp_cmd_i    (dp_cmd),
    .dp_status_o (dp_status),
    .count_o     (count),
    .out_data_o  (out_data_o)
  );

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count <= CntW'(QUEUE_DEPTH))
    else $error("entry count above queue depth");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("new item taken while one is in progress");

  a_no_removal_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.status != fwps_pkg::STATUS_OK) |->
      (out_data_o.out_payload == '0 && out_data_o.out_priority == '0))
    else $error("nonzero entry reported without a removal");

endmodule
